/* hw/rtl/csvs_pkg.sv */
// ----------------------------------------------------------------------------
// csvs_pkg
// Shared types, constants and helpers of the quoted CSV field splitter.
// ----------------------------------------------------------------------------
package csvs_pkg;

  localparam logic [7:0] QUOTE_BYTE      = 8'h22;
  localparam logic [7:0] SEP_RESET       = 8'd44;
  localparam logic [9:0] MAX_CHARS_RESET = 10'd511;
  localparam logic [9:0] COL_MAX         = 10'd1023;

  localparam int unsigned PENDING_DEPTH_DEF = 32;
  localparam int unsigned CMD_FIFO_DEPTH    = 2;

  // configuration register indexes
  localparam logic CFG_SEPARATOR = 1'b0;
  localparam logic CFG_MAX_CHARS = 1'b1;

  typedef enum logic [2:0] {
    M_LEAD,
    M_UNQ,
    M_QUOTED,
    M_QSEEN,
    M_AFTER
  } mode_e;

  typedef enum logic [1:0] {
    OP_PUSH,   // hold one whitespace byte
    OP_FLUSH,  // emit held whitespace, then maybe one character
    OP_CHAR,   // emit one character
    OP_END     // emit a field-end mark and drop held whitespace
  } op_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FETCH,
    B_EMIT_OLD,
    B_CHAR
  } bstate_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       keep;
    logic       line;
    logic       extra;
    logic       trunc;
    logic       uq;
    logic [9:0] column;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       char_valid;
    logic       field_end;
    logic       line_end;
    logic [9:0] field_index;
    logic       extra_chars;
    logic       truncated;
    logic       unclosed_quote;
    logic       last;
  } result_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

endpackage

/* hw/rtl/csvs_front.sv */
// ----------------------------------------------------------------------------
// csvs_front
// Accept bytes, track the parse mode and counters, issue back-end commands.
// ----------------------------------------------------------------------------
module csvs_front
  import csvs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       kind_i,
  input  logic [7:0] in_byte_i,
  input  logic [7:0] separator_i,
  input  logic [9:0] max_chars_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_ready_i
);

  mode_e      mode_q, mode_d;
  logic [9:0] cc_q, cc_d;
  logic [9:0] col_q, col_d;
  logic       junk_q, junk_d;
  logic       ovf_q, ovf_d;
  logic       accept;
  logic       ws, quote, sep, slot;
  logic       cmd_gen;

  assign in_ready_o  = cmd_ready_i;
  assign accept      = in_valid_i & cmd_ready_i;
  assign ws          = is_ws(in_byte_i);
  assign quote       = (in_byte_i == QUOTE_BYTE);
  assign sep         = (in_byte_i == separator_i);
  assign slot        = (cc_q < max_chars_i);
  assign cmd_valid_o = accept & cmd_gen;

  // next mode
  always_comb begin
    mode_d = mode_q;
    if (kind_i) begin
      mode_d = M_LEAD;
    end else begin
      case (mode_q)
        M_LEAD: begin
          if (ws) mode_d = M_LEAD;
          else if (quote) mode_d = M_QUOTED;
          else if (sep) mode_d = M_LEAD;
          else mode_d = M_UNQ;
        end
        M_UNQ:    if (sep) mode_d = M_LEAD;
        M_QUOTED: if (quote) mode_d = M_QSEEN;
        M_QSEEN: begin
          if (quote) mode_d = M_QUOTED;
          else if (sep) mode_d = M_LEAD;
          else mode_d = M_AFTER;
        end
        M_AFTER:  if (sep) mode_d = M_LEAD;
        default:  mode_d = M_LEAD;
      endcase
    end
  end

  // commands and counters
  always_comb begin
    logic end_field, line, uq, qkeep, unq;
    end_field = 1'b0;
    line      = 1'b0;
    uq        = 1'b0;
    qkeep     = 1'b0;
    unq       = 1'b0;
    cmd_gen   = 1'b0;
    cc_d      = cc_q;
    col_d     = col_q;
    junk_d    = junk_q;
    ovf_d     = ovf_q;
    cmd_o.op     = OP_CHAR;
    cmd_o.data   = in_byte_i;
    cmd_o.keep   = 1'b0;
    cmd_o.line   = 1'b0;
    cmd_o.extra  = junk_q;
    cmd_o.trunc  = ovf_q;
    cmd_o.uq     = 1'b0;
    cmd_o.column = col_q;

    if (kind_i) begin
      end_field = 1'b1;
      line      = 1'b1;
      uq        = (mode_q == M_QUOTED);
    end else begin
      case (mode_q)
        M_LEAD: begin
          if (!ws && !quote) begin
            if (sep) end_field = 1'b1;
            else unq = 1'b1;
          end
        end
        M_UNQ: begin
          if (sep) end_field = 1'b1;
          else unq = 1'b1;
        end
        M_QUOTED: qkeep = !quote;
        M_QSEEN: begin
          if (quote) qkeep = 1'b1;
          else if (sep) end_field = 1'b1;
          else if (!ws) junk_d = 1'b1;
        end
        M_AFTER: begin
          if (sep) end_field = 1'b1;
          else if (!ws) junk_d = 1'b1;
        end
        default: ;
      endcase
    end

    if (qkeep) begin
      if (slot) begin
        cmd_gen  = 1'b1;
        cmd_o.op = OP_CHAR;
        cc_d     = cc_q + 10'd1;
      end else begin
        ovf_d = 1'b1;
      end
    end

    if (unq) begin
      if (ws) begin
        if (slot) begin
          cmd_gen  = 1'b1;
          cmd_o.op = OP_PUSH;
          cc_d     = cc_q + 10'd1;
        end else begin
          ovf_d = 1'b1;
        end
      end else begin
        // flush held whitespace even when the character itself is dropped
        cmd_gen    = 1'b1;
        cmd_o.op   = OP_FLUSH;
        cmd_o.keep = slot;
        if (slot) cc_d = cc_q + 10'd1;
        else ovf_d = 1'b1;
      end
    end

    if (end_field) begin
      cmd_gen    = 1'b1;
      cmd_o.op   = OP_END;
      cmd_o.line = line;
      cmd_o.uq   = uq;
      cc_d       = '0;
      junk_d     = 1'b0;
      ovf_d      = 1'b0;
      if (line) col_d = '0;
      else if (col_q != COL_MAX) col_d = col_q + 10'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_LEAD;
      cc_q   <= '0;
      col_q  <= '0;
      junk_q <= 1'b0;
      ovf_q  <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      cc_q   <= cc_d;
      col_q  <= col_d;
      junk_q <= junk_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

/* hw/rtl/csvs_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// csvs_cmd_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module csvs_cmd_fifo
  import csvs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  localparam int unsigned PtrW = $clog2(CMD_FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t            entries_q [CMD_FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(CMD_FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entries_q[wr_ptr_q] <= push_data_i;
  end

endmodule

/* hw/rtl/csvs_back.sv */
// ----------------------------------------------------------------------------
// csvs_back
// Execute commands: hold pending whitespace in a ring memory, emit results.
// ----------------------------------------------------------------------------
module csvs_back
  import csvs_pkg::*;
#(
  parameter int unsigned PENDING_DEPTH = PENDING_DEPTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cmd_valid_i,
  input  cmd_t    cmd_i,
  output logic    cmd_pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  localparam int unsigned PtrW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(PENDING_DEPTH + 1);

  logic [7:0]      mem [PENDING_DEPTH];
  logic [7:0]      rd_data_q;
  logic [PtrW-1:0] rd_ptr_q, wr_ptr_q;
  logic [CntW-1:0] cnt_q;
  bstate_e         state_q, state_d;
  cmd_t            cur_q;
  result_t         res_q, res;
  logic            ovalid_q;
  logic            out_free, full, load;
  logic            mem_we, rd_adv, wr_adv, cnt_inc, cnt_dec, clr;
  logic [7:0]      mem_wdata;

  assign out_free    = ~ovalid_q | out_ready_i;
  assign full        = (cnt_q == CntW'(PENDING_DEPTH));
  assign out_valid_o = ovalid_q;
  assign out_o       = res_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          if ((cmd_i.op == OP_PUSH) && full) state_d = B_FETCH;
          else if ((cmd_i.op == OP_FLUSH) && (cnt_q != '0)) state_d = B_FETCH;
        end
      end
      B_FETCH: state_d = B_EMIT_OLD;
      B_EMIT_OLD: begin
        if (out_free) begin
          if (cur_q.op == OP_PUSH) state_d = B_IDLE;
          else if (cnt_q > CntW'(1)) state_d = B_FETCH;
          else if (cur_q.keep) state_d = B_CHAR;
          else state_d = B_IDLE;
        end
      end
      B_CHAR:  if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    cmd_pop_o = 1'b0;
    load      = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = cmd_i.data;
    rd_adv    = 1'b0;
    wr_adv    = 1'b0;
    cnt_inc   = 1'b0;
    cnt_dec   = 1'b0;
    clr       = 1'b0;
    res.out_byte       = cmd_i.data;
    res.char_valid     = 1'b1;
    res.field_end      = 1'b0;
    res.line_end       = 1'b0;
    res.field_index    = cmd_i.column;
    res.extra_chars    = 1'b0;
    res.truncated      = 1'b0;
    res.unclosed_quote = 1'b0;
    res.last           = 1'b1;

    case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_PUSH: begin
              cmd_pop_o = 1'b1;
              if (!full) begin
                mem_we  = 1'b1;
                wr_adv  = 1'b1;
                cnt_inc = 1'b1;
              end
            end
            OP_FLUSH: begin
              if (cnt_q != '0) begin
                cmd_pop_o = 1'b1;
              end else if (cmd_i.keep) begin
                cmd_pop_o = out_free;
                load      = out_free;
              end else begin
                cmd_pop_o = 1'b1;
              end
            end
            OP_CHAR: begin
              cmd_pop_o = out_free;
              load      = out_free;
            end
            OP_END: begin
              cmd_pop_o          = out_free;
              load               = out_free;
              clr                = out_free;
              res.out_byte       = '0;
              res.char_valid     = 1'b0;
              res.field_end      = 1'b1;
              res.line_end       = cmd_i.line;
              res.extra_chars    = cmd_i.extra;
              res.truncated      = cmd_i.trunc;
              res.unclosed_quote = cmd_i.uq;
            end
            default: ;
          endcase
        end
      end
      B_EMIT_OLD: begin
        res.out_byte    = rd_data_q;
        res.field_index = cur_q.column;
        res.last        = (cur_q.op == OP_PUSH) ||
                          ((cnt_q == CntW'(1)) && !cur_q.keep);
        if (out_free) begin
          load   = 1'b1;
          rd_adv = 1'b1;
          if (cur_q.op == OP_PUSH) begin
            // oldest byte leaves, the new one takes the freed slot
            mem_we    = 1'b1;
            mem_wdata = cur_q.data;
            wr_adv    = 1'b1;
          end else begin
            cnt_dec = 1'b1;
          end
        end
      end
      B_CHAR: begin
        res.out_byte    = cur_q.data;
        res.field_index = cur_q.column;
        load            = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr) begin
        rd_ptr_q <= '0;
        wr_ptr_q <= '0;
        cnt_q    <= '0;
      end else begin
        if (rd_adv) begin
          rd_ptr_q <= (rd_ptr_q == PtrW'(PENDING_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
        end
        if (wr_adv) begin
          wr_ptr_q <= (wr_ptr_q == PtrW'(PENDING_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
        end
        if (cnt_inc) cnt_q <= cnt_q + 1'b1;
        else if (cnt_dec) cnt_q <= cnt_q - 1'b1;
      end
      if (load) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cur_q <= cmd_i;
    if (load) res_q <= res;
  end

  // pending whitespace ring, registered read of the oldest entry
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_ptr_q] <= mem_wdata;
    rd_data_q <= mem[rd_ptr_q];
  end

endmodule

/* hw/rtl/quoted_csv_field_splitter.sv */
// ----------------------------------------------------------------------------
// quoted_csv_field_splitter
// Split a byte stream into delimited, optionally quoted fields.
// ----------------------------------------------------------------------------
//
//  channel   direction  beat carries
//  s_axis    in         tuser = kind (1 = end of line), tdata = in_byte
//  m_axis    out        tuser = char_valid, tdata = result fields, tlast = last
//  cfg       in         cfg_idx_i selects separator (0) or max_field_chars (1)
//
//  The front end takes one byte per cycle while the command queue has room.
//  Characters and field-end marks leave one per cycle while the output is
//  not stalled; each held whitespace byte that is flushed needs a ring
//  memory read, then an emit, and the back end takes no new command until
//  the flush is done; a whitespace byte that pushes the oldest byte out of
//  a full ring also reads and emits that oldest byte.
//  Reset clears all control state at once; the whitespace ring needs no
//  clearing pass since only written entries are ever read.
//  Either side may stall on its own: the queue and the output register
//  decouple input acceptance from result delivery.
//
module quoted_csv_field_splitter
  import csvs_pkg::*;
#(
  parameter int unsigned PENDING_DEPTH = PENDING_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_byte, [8] field_end, [9] line_end, [19:10] field_index,
  // [20] extra_chars, [21] truncated, [22] unclosed_quote, [23] zero
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] char_valid
  output logic        m_axis_tlast,   // last result of the input byte
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [9:0]  cfg_wdata_i
);

  logic [7:0] separator_q;
  logic [9:0] max_chars_q;
  logic       fifo_full, fifo_valid, fifo_pop;
  logic       cmd_push;
  cmd_t       cmd_in, cmd_head;
  result_t    res;

  // Configuration registers; the user must write them only while the block is idle, the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      separator_q <= SEP_RESET;
      max_chars_q <= MAX_CHARS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SEPARATOR: separator_q <= cfg_wdata_i[7:0];
        CFG_MAX_CHARS: max_chars_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Front end: classify each byte and advance the parse state.
  csvs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .kind_i      (s_axis_tuser),
    .in_byte_i   (s_axis_tdata),
    .separator_i (separator_q),
    .max_chars_i (max_chars_q),
    .cmd_valid_o (cmd_push),
    .cmd_o       (cmd_in),
    .cmd_ready_i (~fifo_full)
  );

  // Queue of commands; lets a whitespace flush run while bytes keep arriving.
  csvs_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_push),
    .push_data_i (cmd_in),
    .full_o      (fifo_full),
    .pop_i       (fifo_pop),
    .valid_o     (fifo_valid),
    .head_o      (cmd_head)
  );

  // Back end: hold trailing whitespace and drive the result register.
  csvs_back #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (fifo_valid),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (fifo_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  // Pack the result fields onto the stream.
  assign m_axis_tdata = {1'b0, res.unclosed_quote, res.truncated, res.extra_chars,
                         res.field_index, res.line_end, res.field_end, res.out_byte};
  assign m_axis_tuser = res.char_valid;
  assign m_axis_tlast = res.last;

endmodule

/* hw/rtl/csvs_checker.sv */
// ----------------------------------------------------------------------------
// csvs_checker
// Port-level assertions for the quoted CSV field splitter.
// ----------------------------------------------------------------------------
module csvs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // every result is either a character or a field-end mark
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != m_axis_tdata[8]))
    else $error("result is neither character nor field end");

  // character results carry no status flags
  a_char_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[22:20] == 3'b000) && !m_axis_tdata[9])
    else $error("status flag on character result");

  // a field-end mark is always the final result of its byte, with a zero byte
  a_mark_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tlast && (m_axis_tdata[7:0] == 8'd0))
    else $error("field end not last or carries a byte");

  // a line end restarts the column count
  a_line_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tdata[9] ##1 m_axis_tvalid |->
      (m_axis_tdata[19:10] == 10'd0))
    else $error("column not restarted after line end");

endmodule

bind quoted_csv_field_splitter csvs_checker u_csvs_checker (.*);
